// ----- rtl/aps_pkg.sv -----
// ----------------------------------------------------------------------------
// Aging priority scheduler package
// Transfer payload types, command and status codes, and the clamp applied to
// requested priorities on enqueue.
// ----------------------------------------------------------------------------
`default_nettype none

package aps_pkg;

    localparam int unsigned ENTRY_VALUE_W = 32;
    localparam int unsigned REQ_PRIO_W    = 8;
    localparam int unsigned STATUS_W      = 2;
    localparam int unsigned CLAMP_W       = 4;

    localparam logic [CLAMP_W-1:0] PRIO_MAX_REQUEST = 4'd10;

    localparam logic CMD_ENQUEUE = 1'b0;
    localparam logic CMD_DEQUEUE = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic                             command;
        logic signed [ENTRY_VALUE_W-1:0]  entry_value;
        logic signed [REQ_PRIO_W-1:0]     requested_priority;
    } t_in_item;

    typedef struct packed {
        logic signed [ENTRY_VALUE_W-1:0]  removed_value;
        logic        [STATUS_W-1:0]       status;
    } t_out_item;

    // Negative requests become zero, requests above the maximum are capped.
    function automatic logic [CLAMP_W-1:0] clamp_request(
        input logic signed [REQ_PRIO_W-1:0] req
    );
        logic [CLAMP_W-1:0] res;
        if (req[REQ_PRIO_W-1]) begin
            res = '0;
        end else if (req > $signed({{(REQ_PRIO_W-CLAMP_W){1'b0}}, PRIO_MAX_REQUEST})) begin
            res = PRIO_MAX_REQUEST;
        end else begin
            res = req[CLAMP_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/aps_slot_mem.sv -----
// ----------------------------------------------------------------------------
// Aging priority scheduler slot memory
// Simple dual-port storage: one write port and one read port with registered
// read data. Holds each entry's value and priority side by side.
// ----------------------------------------------------------------------------
`default_nettype none

module aps_slot_mem #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned WIDTH = 40
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/aging_priority_scheduler.sv -----
// ----------------------------------------------------------------------------
// Aging priority scheduler
// Priority table of up to CAPACITY entries kept in arrival order, with
// removal of the highest priority entry and aging of the rest.
// ----------------------------------------------------------------------------
// Usage. Commands arrive on the input channel (i_in_valid / o_in_ready /
// i_in_data) and each gives exactly one result on the output channel
// (o_out_valid / i_out_ready / o_out_data). A transfer happens on a rising
// edge at which valid and ready are both high.
// An enqueue, or a command that is rejected because the table is full or
// empty, is answered from the idle state: its result is presented on the
// edge after the input transfer. A successful dequeue walks the table twice
// through a single memory read port, once to find the winner and once to
// close the gap and age the survivors; its result is presented when the
// second walk has returned the last stored entry.
// Commands are taken one at a time. The input is ready only while the
// sequencer is idle and the output register is empty or being emptied in the
// same cycle, so a stalled receiver holds the result and stops new commands.
// Reset empties the table and the output register at once; no clearing pass
// is needed because only slots below the occupancy are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module aging_priority_scheduler
    import aps_pkg::*;
#(
    parameter int unsigned CAPACITY              = 16,
    parameter int unsigned AGED_PRIORITY_CEILING = 255
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output      logic      o_in_ready,
    input  wire t_in_item  i_in_data,
    output      logic      o_out_valid,
    input  wire logic      i_out_ready,
    output      t_out_item o_out_data
);

    localparam int unsigned IDX_W = $clog2(CAPACITY);
    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
    localparam int unsigned PRI_W = $clog2(AGED_PRIORITY_CEILING + 1);
    localparam int unsigned ENT_W = ENTRY_VALUE_W + PRI_W;

    localparam logic [CNT_W-1:0] CAP_C  = CNT_W'(CAPACITY);
    localparam logic [PRI_W-1:0] CEIL_C = PRI_W'(AGED_PRIORITY_CEILING);

    // Sequencer states.
    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_SCAN    = 2'd1;
    localparam logic [1:0] ST_COMPACT = 2'd2;

    logic [1:0]               r_state,     n_state;
    logic [CNT_W-1:0]         r_occ,       n_occ;
    logic [CNT_W-1:0]         r_idx,       n_idx;
    logic                     r_rd_vld,    n_rd_vld;
    logic [IDX_W-1:0]         r_rd_idx,    n_rd_idx;
    logic [IDX_W-1:0]         r_best_idx,  n_best_idx;
    logic [PRI_W-1:0]         r_best_pri,  n_best_pri;
    logic [ENTRY_VALUE_W-1:0] r_best_val,  n_best_val;
    logic                     r_out_valid, n_out_valid;
    t_out_item                r_out,       n_out;

    logic                     in_fire;
    logic                     issue;
    logic                     last_ret;
    logic [IDX_W-1:0]         last_idx;
    logic                     mem_we;
    logic [IDX_W-1:0]         mem_waddr;
    logic [ENT_W-1:0]         mem_wdata;
    logic [ENT_W-1:0]         mem_rdata;
    logic [ENTRY_VALUE_W-1:0] rd_val;
    logic [PRI_W-1:0]         rd_pri;
    logic [PRI_W-1:0]         aged_pri;

    aps_slot_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (ENT_W)
    ) u_slot_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_idx[IDX_W-1:0]),
        .o_rdata (mem_rdata)
    );

    // The input side opens only when the sequencer is idle and the single
    // result this command will produce has somewhere to go.
    assign o_in_ready = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign in_fire    = i_in_valid && o_in_ready;

    // Both walks issue one read per cycle over slots 0 .. occupancy-1; the
    // data returns in the next cycle tagged with its index.
    assign issue    = (r_state != ST_IDLE) && (r_idx < r_occ);
    assign last_idx = IDX_W'(r_occ - 1'b1);
    assign last_ret = r_rd_vld && (r_rd_idx == last_idx);

    assign rd_val   = mem_rdata[ENT_W-1:PRI_W];
    assign rd_pri   = mem_rdata[PRI_W-1:0];
    assign aged_pri = (rd_pri < CEIL_C) ? rd_pri + 1'b1 : CEIL_C;

    // Write port: an enqueue appends at the back; during compaction every
    // survivor is written back aged, those behind the winner one slot lower.
    // The write address never exceeds the index being read, so the walk
    // always reads entries that have not yet been moved.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_rd_idx;
        mem_wdata = {rd_val, aged_pri};
        if (r_state == ST_IDLE) begin
            mem_we    = in_fire && (i_in_data.command == CMD_ENQUEUE) && (r_occ != CAP_C);
            mem_waddr = r_occ[IDX_W-1:0];
            mem_wdata = {i_in_data.entry_value,
                         PRI_W'(clamp_request(i_in_data.requested_priority))};
        end else if (r_state == ST_COMPACT) begin
            mem_we = r_rd_vld && (r_rd_idx != r_best_idx);
            if (r_rd_idx > r_best_idx) begin
                mem_waddr = r_rd_idx - 1'b1;
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_occ       = r_occ;
        n_idx       = issue ? r_idx + 1'b1 : r_idx;
        n_rd_vld    = issue;
        n_rd_idx    = r_idx[IDX_W-1:0];
        n_best_idx  = r_best_idx;
        n_best_pri  = r_best_pri;
        n_best_val  = r_best_val;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;

        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_out.removed_value = '0;
                    n_out.status        = STATUS_OK;
                    if (i_in_data.command == CMD_ENQUEUE) begin
                        n_out_valid = 1'b1;
                        if (r_occ == CAP_C) begin
                            n_out.status = STATUS_FULL;
                        end else begin
                            n_occ = r_occ + 1'b1;
                        end
                    end else if (r_occ == '0) begin
                        n_out_valid  = 1'b1;
                        n_out.status = STATUS_EMPTY;
                    end else begin
                        n_state = ST_SCAN;
                        n_idx   = '0;
                    end
                end
            end
            ST_SCAN: begin
                // Strictly greater keeps the oldest entry among equals.
                if (r_rd_vld && ((r_rd_idx == '0) || (rd_pri > r_best_pri))) begin
                    n_best_idx = r_rd_idx;
                    n_best_pri = rd_pri;
                    n_best_val = rd_val;
                end
                if (last_ret) begin
                    n_state = ST_COMPACT;
                    n_idx   = '0;
                end
            end
            ST_COMPACT: begin
                if (last_ret) begin
                    n_state             = ST_IDLE;
                    n_occ               = r_occ - 1'b1;
                    n_out_valid         = 1'b1;
                    n_out.removed_value = r_best_val;
                    n_out.status        = STATUS_OK;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_occ       <= '0;
            r_idx       <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_occ       <= n_occ;
            r_idx       <= n_idx;
            r_rd_vld    <= n_rd_vld;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx   <= n_rd_idx;
        r_best_idx <= n_best_idx;
        r_best_pri <= n_best_pri;
        r_best_val <= n_best_val;
        r_out      <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// ----- rtl/aps_checker.sv -----
// ----------------------------------------------------------------------------
// Aging priority scheduler port checker
// Watches the top level's ports for handshake and result consistency.
// ----------------------------------------------------------------------------
`default_nettype none

module aps_checker
    import aps_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      o_in_ready,
    input wire t_in_item  i_in_data,
    input wire logic      o_out_valid,
    input wire logic      i_out_ready,
    input wire t_out_item o_out_data
);

    // A pending result is held, unchanged, until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result dropped or changed while stalled");

    // No new command is taken while a result is stuck at the output.
    a_no_accept_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input ready while output stalled");

    // Only defined status codes appear.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.status == STATUS_OK) ||
                        (o_out_data.status == STATUS_EMPTY) ||
                        (o_out_data.status == STATUS_FULL))
        else $error("undefined status code");

    // A rejected command carries a zero value.
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status != STATUS_OK) |-> o_out_data.removed_value == '0)
        else $error("non-zero value on rejected command");

    // An accepted enqueue answers on the next edge.
    a_enqueue_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_in_data.command == CMD_ENQUEUE) |=> o_out_valid)
        else $error("enqueue result late");

endmodule

bind aging_priority_scheduler aps_checker u_aps_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire
